// ===== src/uvsti_pkg.sv =====
// Package for the UV sphere triangle indexer: widths, codes, types and geometry derivation.
`default_nettype none

package uvsti_pkg;

    localparam int TN_W      = 17;
    localparam int VTX_W     = 16;
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 2;
    localparam int SEG_W     = 9;
    localparam int DIV_W     = SEG_W + 1;

    localparam int MAX_RINGS_DEF    = 256;
    localparam int MAX_SEGMENTS_DEF = 256;

    localparam logic [CFG_W-1:0] RST_LAT  = 9'd10;
    localparam logic [CFG_W-1:0] RST_LONG = 9'd10;

    localparam logic [CFG_IDX_W-1:0] CFG_LAT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG = 2'd1;

    localparam logic [1:0] REG_TOP  = 2'd0;
    localparam logic [1:0] REG_BAND = 2'd1;
    localparam logic [1:0] REG_BOT  = 2'd2;
    localparam logic [1:0] REG_OOR  = 2'd3;

    typedef struct packed {
        logic [1:0]       region;
        logic [VTX_W-1:0] v0;
        logic [VTX_W-1:0] v1;
        logic [VTX_W-1:0] v2;
    } side_t;

    typedef struct packed {
        logic [SEG_W-1:0] seg;
        logic [DIV_W-1:0] div;
        logic [TN_W-1:0]  faces;
        logic [TN_W-1:0]  band;
        logic [VTX_W-1:0] last;
    } geom_t;

    function automatic geom_t derive(
        input logic [CFG_W-1:0] lat,
        input logic [CFG_W-1:0] lon,
        input logic [CFG_W-1:0] max_r,
        input logic [CFG_W-1:0] max_s
    );
        logic [CFG_W-1:0] r;
        logic [CFG_W-1:0] s;
        logic [TN_W-1:0]  p;
        geom_t            g;
        if (lat < 9'd3) begin
            r = 9'd3;
        end else if (lat > max_r) begin
            r = max_r;
        end else begin
            r = lat;
        end
        if (lon < 9'd3) begin
            s = 9'd3;
        end else if (lon > max_s) begin
            s = max_s;
        end else begin
            s = lon;
        end
        p       = TN_W'(r - 9'd2) * TN_W'(s);
        g.seg   = s;
        g.div   = {s, 1'b0};
        g.faces = {p[VTX_W-1:0], 1'b0};
        g.band  = g.faces - TN_W'({s, 1'b0});
        g.last  = p[VTX_W-1:0] + 16'd1;
        return g;
    endfunction

endpackage

`default_nettype wire

// ===== src/uvsti_divider.sv =====
// Pipelined restoring divider: one quotient bit per stage, sideband carried along.
`default_nettype none

module uvsti_divider #(
    parameter int QW = 8
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic [uvsti_pkg::DIV_W-1:0]     divisor,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [uvsti_pkg::TN_W-1:0]      in_rem,
    input  wire uvsti_pkg::side_t                in_side,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [uvsti_pkg::TN_W-1:0]           out_rem,
    output logic [QW-1:0]                        out_quot,
    output uvsti_pkg::side_t                     out_side
);

    localparam int CW = uvsti_pkg::TN_W + uvsti_pkg::DIV_W + QW;

    logic                          valid_reg [QW];
    logic [uvsti_pkg::TN_W-1:0]    rem_reg   [QW];
    logic [QW-1:0]                 quot_reg  [QW];
    uvsti_pkg::side_t              side_reg  [QW];
    logic                          stage_ready [QW+1];

    assign stage_ready[QW] = out_ready;
    assign in_ready        = stage_ready[0];
    assign out_valid       = valid_reg[QW-1];
    assign out_rem         = rem_reg[QW-1];
    assign out_quot        = quot_reg[QW-1];
    assign out_side        = side_reg[QW-1];

    for (genvar i = 0; i < QW; i++) begin : g_stage
        localparam int K = QW - 1 - i;

        logic                       valid_in;
        logic [uvsti_pkg::TN_W-1:0] rem_in;
        logic [QW-1:0]              quot_in;
        uvsti_pkg::side_t           side_in;
        logic [uvsti_pkg::TN_W-1:0] rem_next;
        logic [QW-1:0]              quot_next;
        logic [CW-1:0]              shifted;
        logic [CW-1:0]              rem_ext;

        if (i == 0) begin : g_first
            assign valid_in = in_valid;
            assign rem_in   = in_rem;
            assign quot_in  = '0;
            assign side_in  = in_side;
        end else begin : g_rest
            assign valid_in = valid_reg[i-1];
            assign rem_in   = rem_reg[i-1];
            assign quot_in  = quot_reg[i-1];
            assign side_in  = side_reg[i-1];
        end

        always_comb begin
            shifted = CW'(divisor) << K;
            rem_ext = CW'(rem_in);
            if (rem_ext >= shifted) begin
                rem_next  = uvsti_pkg::TN_W'(rem_ext - shifted);
                quot_next = quot_in | (QW'(1) << K);
            end else begin
                rem_next  = rem_in;
                quot_next = quot_in;
            end
        end

        assign stage_ready[i] = !valid_reg[i] || stage_ready[i+1];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[i] <= 1'b0;
            end else if (stage_ready[i]) begin
                valid_reg[i] <= valid_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (stage_ready[i] && valid_in) begin
                rem_reg[i]  <= rem_next;
                quot_reg[i] <= quot_next;
                side_reg[i] <= side_in;
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/uv_sphere_triangle_indexer.sv =====
// Top level of the UV sphere triangle indexer.
`default_nettype none

// Maps a triangle number to its three vertex indices in a latitude-longitude
// sphere mesh (top cap fan, two-triangle band quads, bottom cap fan). One
// transfer is taken every cycle unless the output stalls; a result passes
// the input register, the pipelined divider that splits the band offset into
// ring and column one quotient bit per stage, stage E and the output
// register. Every stage has its own valid bit, so bubbles close up and the
// input keeps flowing while a finished result waits on the output register.
// Configuration writes reach every stage from the next cycle, so write only
// while no transfer is in flight; writes to unknown indexes are ignored.

module uv_sphere_triangle_indexer #(
    parameter int MAX_RINGS    = uvsti_pkg::MAX_RINGS_DEF,
    parameter int MAX_SEGMENTS = uvsti_pkg::MAX_SEGMENTS_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_wr_en,
    input  wire logic [uvsti_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [uvsti_pkg::CFG_W-1:0]      cfg_wdata,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [uvsti_pkg::TN_W-1:0]       s_triangle_number,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [uvsti_pkg::VTX_W-1:0]           m_first_vertex,
    output logic [uvsti_pkg::VTX_W-1:0]           m_second_vertex,
    output logic [uvsti_pkg::VTX_W-1:0]           m_third_vertex,
    output logic                                  m_out_of_range
);

    localparam int QW = $clog2(MAX_RINGS);
    localparam int SW = uvsti_pkg::SEG_W;
    localparam int TW = uvsti_pkg::TN_W;
    localparam int VW = uvsti_pkg::VTX_W;

    // configuration
    logic [uvsti_pkg::CFG_W-1:0] lat_reg, lat_next;
    logic [uvsti_pkg::CFG_W-1:0] long_reg, long_next;
    uvsti_pkg::geom_t            geom_reg;

    always_comb begin
        lat_next  = lat_reg;
        long_next = long_reg;
        if (cfg_wr_en) begin
            if (cfg_index == uvsti_pkg::CFG_LAT) begin
                lat_next = cfg_wdata;
            end else if (cfg_index == uvsti_pkg::CFG_LONG) begin
                long_next = cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lat_reg  <= uvsti_pkg::RST_LAT;
            long_reg <= uvsti_pkg::RST_LONG;
            geom_reg <= uvsti_pkg::derive(uvsti_pkg::RST_LAT, uvsti_pkg::RST_LONG,
                                          9'(MAX_RINGS), 9'(MAX_SEGMENTS));
        end else begin
            lat_reg  <= lat_next;
            long_reg <= long_next;
            geom_reg <= uvsti_pkg::derive(lat_next, long_next,
                                          9'(MAX_RINGS), 9'(MAX_SEGMENTS));
        end
    end

    // stage A: input register and region decode
    logic          a_valid_reg;
    logic [TW-1:0] a_tn_reg;
    logic          a_ready;
    logic          div_in_ready;

    assign a_ready = !a_valid_reg || div_in_ready;
    assign s_ready = a_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (a_ready) begin
            a_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_ready && s_valid) begin
            a_tn_reg <= s_triangle_number;
        end
    end

    logic [TW-1:0]    seg_ext;
    logic [TW-1:0]    band_ofs;
    logic [TW-1:0]    bot_ofs;
    logic [TW-1:0]    t_inc;
    logic [TW-1:0]    l_inc;
    uvsti_pkg::side_t a_side;

    always_comb begin
        seg_ext  = TW'(geom_reg.seg);
        band_ofs = a_tn_reg - seg_ext;
        bot_ofs  = band_ofs - geom_reg.band;
        t_inc    = a_tn_reg + 17'd1;
        l_inc    = bot_ofs + 17'd1;
        a_side   = '0;
        if (a_tn_reg >= geom_reg.faces) begin
            a_side.region = uvsti_pkg::REG_OOR;
        end else if (a_tn_reg < seg_ext) begin
            a_side.region = uvsti_pkg::REG_TOP;
            a_side.v1     = t_inc[VW-1:0];
            a_side.v2     = (t_inc == seg_ext) ? 16'd1 : VW'(a_tn_reg + 17'd2);
        end else if (band_ofs < geom_reg.band) begin
            a_side.region = uvsti_pkg::REG_BAND;
        end else begin
            a_side.region = uvsti_pkg::REG_BOT;
            a_side.v0     = geom_reg.last;
            a_side.v1     = geom_reg.last - l_inc[VW-1:0];
            a_side.v2     = geom_reg.last -
                            ((l_inc == seg_ext) ? 16'd1 : VW'(bot_ofs + 17'd2));
        end
    end

    // ring / column split
    logic             div_out_valid;
    logic             e_ready;
    logic [TW-1:0]    div_rem;
    logic [QW-1:0]    div_quot;
    uvsti_pkg::side_t div_side;

    uvsti_divider #(
        .QW (QW)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .divisor   (geom_reg.div),
        .in_valid  (a_valid_reg),
        .in_ready  (div_in_ready),
        .in_rem    (band_ofs),
        .in_side   (a_side),
        .out_valid (div_out_valid),
        .out_ready (e_ready),
        .out_rem   (div_rem),
        .out_quot  (div_quot),
        .out_side  (div_side)
    );

    // stage E: ring base and column offsets
    logic             e_valid_reg;
    uvsti_pkg::side_t e_side_reg;
    logic [VW-1:0]    e_up_reg;
    logic [SW-1:0]    e_a_reg;
    logic [SW-1:0]    e_b_reg;
    logic             e_odd_reg;
    logic             f_ready;

    logic [31:0]      up_prod;
    logic [SW-1:0]    a_next;
    logic [SW-1:0]    b_next;

    always_comb begin
        up_prod = 32'(div_quot) * 32'(geom_reg.seg);
        a_next  = SW'(div_rem[SW-1:1]) + 9'd1;
        b_next  = (a_next == geom_reg.seg) ? 9'd1 : a_next + 9'd1;
    end

    assign e_ready = !e_valid_reg || f_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_valid_reg <= 1'b0;
        end else if (e_ready) begin
            e_valid_reg <= div_out_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (e_ready && div_out_valid) begin
            e_side_reg <= div_side;
            e_up_reg   <= up_prod[VW-1:0];
            e_a_reg    <= a_next;
            e_b_reg    <= b_next;
            e_odd_reg  <= div_rem[0];
        end
    end

    // stage F: output register
    logic          f_valid_reg;
    logic [VW-1:0] f_v0_reg, f_v0_next;
    logic [VW-1:0] f_v1_reg, f_v1_next;
    logic [VW-1:0] f_v2_reg, f_v2_next;
    logic          f_oor_reg, f_oor_next;
    logic [VW-1:0] dn;
    logic [VW-1:0] up_a, up_b, dn_a, dn_b;

    always_comb begin
        dn   = e_up_reg + VW'(geom_reg.seg);
        up_a = e_up_reg + VW'(e_a_reg);
        up_b = e_up_reg + VW'(e_b_reg);
        dn_a = dn + VW'(e_a_reg);
        dn_b = dn + VW'(e_b_reg);
        f_v0_next  = e_side_reg.v0;
        f_v1_next  = e_side_reg.v1;
        f_v2_next  = e_side_reg.v2;
        f_oor_next = 1'b0;
        case (e_side_reg.region)
            uvsti_pkg::REG_BAND: begin
                f_v0_next = e_odd_reg ? dn_a : up_a;
                f_v1_next = up_b;
                f_v2_next = e_odd_reg ? dn_b : dn_a;
            end
            uvsti_pkg::REG_OOR: begin
                f_v0_next  = '0;
                f_v1_next  = '0;
                f_v2_next  = '0;
                f_oor_next = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign f_ready = !f_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else if (f_ready) begin
            f_valid_reg <= e_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (f_ready && e_valid_reg) begin
            f_v0_reg  <= f_v0_next;
            f_v1_reg  <= f_v1_next;
            f_v2_reg  <= f_v2_next;
            f_oor_reg <= f_oor_next;
        end
    end

    assign m_valid         = f_valid_reg;
    assign m_first_vertex  = f_v0_reg;
    assign m_second_vertex = f_v1_reg;
    assign m_third_vertex  = f_v2_reg;
    assign m_out_of_range  = f_oor_reg;

`ifndef ASSERT_OFF
    a_oor_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_out_of_range |->
            m_first_vertex == '0 && m_second_vertex == '0 && m_third_vertex == '0)
        else $error("out-of-range result with nonzero vertices");

    a_distinct: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_out_of_range |->
            m_first_vertex != m_second_vertex && m_second_vertex != m_third_vertex &&
            m_first_vertex != m_third_vertex)
        else $error("degenerate triangle");

    a_in_mesh: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_out_of_range |->
            m_first_vertex <= geom_reg.last && m_second_vertex <= geom_reg.last &&
            m_third_vertex <= geom_reg.last)
        else $error("vertex index beyond the mesh");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("pipeline not empty after reset");
`endif

endmodule

`default_nettype wire
